[src/evf_pkg.sv]
`timescale 1ns / 1ps

package evf_pkg;

    localparam int COORD_W        = 32;
    localparam int IDX_OUT_W      = 16;
    localparam int NUM_AXES       = 3;
    localparam int NUM_DIRS       = 6;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int NUM_REGS       = 6;
    localparam int MAX_VERTICES_DEF = 65536;
    localparam int FIFO_DEPTH     = 8;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_X_AB = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_X_CT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_Y_AB = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_Y_CT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_Z_AB = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_Z_CT = 3'd5;

    // Reset values form the identity transform.
    localparam logic [CFG_DATA_W-1:0] RST_ROW_X_AB = 64'h0000_0000_0001_0000;
    localparam logic [CFG_DATA_W-1:0] RST_ROW_X_CT = 64'h0000_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_ROW_Y_AB = 64'h0001_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_ROW_Y_CT = 64'h0000_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_ROW_Z_AB = 64'h0000_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_ROW_Z_CT = 64'h0000_0000_0001_0000;

    // One transformed vertex as it travels from the front to the back.
    typedef struct packed {
        logic [NUM_AXES-1:0][COORD_W-1:0] coord;
        logic                             last;
    } xf_item_t;

endpackage

[src/axis_extreme_vertex_finder_unit.sv]
`timescale 1ns / 1ps
// Throughput: one vertex item per clock cycle while the queue has room; a last
// item waits while an unread result is held in the output register. A result
// passes three transform stages, the queue and the compare-and-keep register.
// The six compare-and-keep updates in the back part set the one-cycle rate.
// Reset (aresetn, synchronous, active low) restores the identity transform and
// clears the per-mesh state, the queue and the output register.

module axis_extreme_vertex_finder_unit #(
    parameter int MAX_VERTICES = evf_pkg::MAX_VERTICES_DEF
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            cfg_wr_en,
    input  logic [evf_pkg::CFG_ADDR_W-1:0]                  cfg_addr,
    input  logic [evf_pkg::CFG_DATA_W-1:0]                  cfg_wdata,
    input  logic                                            s_tvalid,
    output logic                                            s_tready,
    // s_tdata: pos_x [31:0], pos_y [63:32], pos_z [95:64]
    input  logic [3*evf_pkg::COORD_W-1:0]                   s_tdata,
    input  logic                                            s_tlast,
    output logic                                            m_tvalid,
    input  logic                                            m_tready,
    // m_tdata: idx_pos_x, idx_neg_x, idx_pos_y, idx_neg_y, idx_pos_z,
    // idx_neg_z, 16 bits each from bit 0 up
    output logic [evf_pkg::NUM_DIRS*evf_pkg::IDX_OUT_W-1:0] m_tdata,
    // m_tuser: too_many [0]
    output logic                                            m_tuser
);
    import evf_pkg::*;

    localparam int FCW = $clog2(FIFO_DEPTH + 1);

    logic            in_fire;
    logic            xf_valid;
    xf_item_t        xf_item;
    logic [1:0]      in_flight;
    logic            q_not_empty;
    xf_item_t        q_head;
    logic            q_pop;
    logic [FCW-1:0]  q_count;
    logic [FCW:0]    q_reserved;

    // Items in the transform pipeline have a queue slot held for them.
    assign q_reserved = (FCW+1)'(q_count) + (FCW+1)'(in_flight);
    assign s_tready   = q_reserved < (FCW+1)'(FIFO_DEPTH);
    assign in_fire    = s_tvalid && s_tready;

    evf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_fire),
        .in_x      (s_tdata[COORD_W-1:0]),
        .in_y      (s_tdata[2*COORD_W-1:COORD_W]),
        .in_z      (s_tdata[3*COORD_W-1:2*COORD_W]),
        .in_last   (s_tlast),
        .out_valid (xf_valid),
        .out_item  (xf_item),
        .in_flight (in_flight)
    );

    evf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (xf_valid),
        .push_item (xf_item),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (q_head),
        .count     (q_count)
    );

    evf_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (q_not_empty),
        .item       (q_head),
        .item_pop   (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

[src/evf_front.sv]
`timescale 1ns / 1ps

module evf_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [evf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [evf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           in_valid,
    input  logic [evf_pkg::COORD_W-1:0]    in_x,
    input  logic [evf_pkg::COORD_W-1:0]    in_y,
    input  logic [evf_pkg::COORD_W-1:0]    in_z,
    input  logic                           in_last,
    output logic                           out_valid,
    output evf_pkg::xf_item_t              out_item,
    output logic [1:0]                     in_flight
);
    import evf_pkg::*;

    logic [NUM_REGS-1:0][CFG_DATA_W-1:0] cfg_reg;

    logic                                v1_reg, v2_reg, v3_reg;
    logic                                l1_reg, l2_reg, l3_reg;
    logic signed [63:0]                  prod_reg [NUM_AXES][3];
    logic signed [63:0]                  prod_next [NUM_AXES][3];
    logic signed [65:0]                  sum_reg  [NUM_AXES];
    logic signed [65:0]                  sum_next [NUM_AXES];
    logic [NUM_AXES-1:0][COORD_W-1:0]    crd_reg;
    logic [NUM_AXES-1:0][COORD_W-1:0]    crd_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[REG_ROW_X_AB] <= RST_ROW_X_AB;
            cfg_reg[REG_ROW_X_CT] <= RST_ROW_X_CT;
            cfg_reg[REG_ROW_Y_AB] <= RST_ROW_Y_AB;
            cfg_reg[REG_ROW_Y_CT] <= RST_ROW_Y_CT;
            cfg_reg[REG_ROW_Z_AB] <= RST_ROW_Z_AB;
            cfg_reg[REG_ROW_Z_CT] <= RST_ROW_Z_CT;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ROW_X_AB: cfg_reg[REG_ROW_X_AB] <= cfg_wdata;
                REG_ROW_X_CT: cfg_reg[REG_ROW_X_CT] <= cfg_wdata;
                REG_ROW_Y_AB: cfg_reg[REG_ROW_Y_AB] <= cfg_wdata;
                REG_ROW_Y_CT: cfg_reg[REG_ROW_Y_CT] <= cfg_wdata;
                REG_ROW_Z_AB: cfg_reg[REG_ROW_Z_AB] <= cfg_wdata;
                REG_ROW_Z_CT: cfg_reg[REG_ROW_Z_CT] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage 1: nine 32x32 products. Stage 2: row sums. Stage 3: floor shift,
    // translation and saturation. Summing the full products before the shift
    // gives the exact floor of the whole row.
    always_comb begin
        for (int r = 0; r < NUM_AXES; r++) begin
            prod_next[r][0] = $signed(cfg_reg[2*r][31:0])    * $signed(in_x);
            prod_next[r][1] = $signed(cfg_reg[2*r][63:32])   * $signed(in_y);
            prod_next[r][2] = $signed(cfg_reg[2*r+1][31:0])  * $signed(in_z);
            sum_next[r] = 66'(prod_reg[r][0]) + 66'(prod_reg[r][1])
                        + 66'(prod_reg[r][2]);
        end
    end

    always_comb begin
        logic signed [50:0] s;
        for (int r = 0; r < NUM_AXES; r++) begin
            s = 51'($signed(sum_reg[r][65:16])) + 51'($signed(cfg_reg[2*r+1][63:32]));
            if (s[50:31] == {20{s[50]}}) begin
                crd_next[r] = s[31:0];
            end else if (s[50]) begin
                crd_next[r] = 32'h8000_0000;
            end else begin
                crd_next[r] = 32'h7FFF_FFFF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        l1_reg  <= in_last;
        l2_reg  <= l1_reg;
        l3_reg  <= l2_reg;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        crd_reg  <= crd_next;
    end

    assign out_valid      = v3_reg;
    assign out_item.coord = crd_reg;
    assign out_item.last  = l3_reg;
    assign in_flight      = 2'({1'b0, v1_reg} + {1'b0, v2_reg} + {1'b0, v3_reg});

endmodule

[src/evf_fifo.sv]
`timescale 1ns / 1ps

module evf_fifo #(
    parameter int DEPTH = evf_pkg::FIFO_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           push,
    input  evf_pkg::xf_item_t              push_item,
    input  logic                           pop,
    output logic                           not_empty,
    output evf_pkg::xf_item_t              head_item,
    output logic [$clog2(DEPTH+1)-1:0]     count
);
    import evf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    xf_item_t        mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && !pop && count_reg == CW'(DEPTH)))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && count_reg == '0))
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

[src/evf_back.sv]
`timescale 1ns / 1ps

module evf_back #(
    parameter int MAX_VERTICES = evf_pkg::MAX_VERTICES_DEF
) (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  logic                                                item_valid,
    input  evf_pkg::xf_item_t                                   item,
    output logic                                                item_pop,
    output logic                                                m_tvalid,
    input  logic                                                m_tready,
    output logic [evf_pkg::NUM_DIRS*evf_pkg::IDX_OUT_W-1:0]     m_tdata,
    output logic                                                m_tuser
);
    import evf_pkg::*;

    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic                                  seen_first_reg;
    logic [CW-1:0]                         counter_reg, counter_next;
    logic                                  overflow_reg, overflow_next;
    logic signed [COORD_W-1:0]             ext_coord_reg [NUM_DIRS];
    logic signed [COORD_W-1:0]             ext_coord_next [NUM_DIRS];
    logic [IW-1:0]                         ext_idx_reg [NUM_DIRS];
    logic [IW-1:0]                         ext_idx_next [NUM_DIRS];
    logic [IW-1:0]                         idx_cur;
    logic                                  out_valid_reg;
    logic [NUM_DIRS*IDX_OUT_W-1:0]         out_data_reg;
    logic                                  out_user_reg;

    // A last item can only go when the output register is free or draining.
    assign item_pop = item_valid && (!item.last || !out_valid_reg || m_tready);

    always_comb begin
        logic signed [COORD_W-1:0] v;
        logic                      take;
        if (counter_reg < CW'(MAX_VERTICES)) begin
            idx_cur       = counter_reg[IW-1:0];
            counter_next  = counter_reg + 1'b1;
            overflow_next = overflow_reg;
        end else begin
            idx_cur       = IW'(MAX_VERTICES - 1);
            counter_next  = counter_reg;
            overflow_next = 1'b1;
        end
        for (int k = 0; k < NUM_DIRS; k++) begin
            v = $signed(item.coord[k >> 1]);
            if (!seen_first_reg) begin
                take = 1'b1;
            end else if ((k % 2) == 0) begin
                take = v > ext_coord_reg[k];
            end else begin
                take = v < ext_coord_reg[k];
            end
            ext_coord_next[k] = take ? v       : ext_coord_reg[k];
            ext_idx_next[k]   = take ? idx_cur : ext_idx_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_first_reg <= 1'b0;
            counter_reg    <= '0;
            overflow_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (item_pop && item.last) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (item_pop) begin
                if (item.last) begin
                    seen_first_reg <= 1'b0;
                    counter_reg    <= '0;
                    overflow_reg   <= 1'b0;
                end else begin
                    seen_first_reg <= 1'b1;
                    counter_reg    <= counter_next;
                    overflow_reg   <= overflow_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_pop) begin
            ext_coord_reg <= ext_coord_next;
            ext_idx_reg   <= ext_idx_next;
            if (item.last) begin
                for (int k = 0; k < NUM_DIRS; k++) begin
                    out_data_reg[k*IDX_OUT_W +: IDX_OUT_W] <= IDX_OUT_W'(ext_idx_next[k]);
                end
                out_user_reg <= overflow_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef ASSERT_OFF
    a_ovf_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |-> counter_reg == CW'(MAX_VERTICES))
        else $error("overflow flag set below the vertex limit");
    a_fresh_mesh: assert property (@(posedge aclk) disable iff (!aresetn)
        !seen_first_reg |-> (counter_reg == '0 && !overflow_reg))
        else $error("mesh state not clear before first vertex");
    a_no_result_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        !(item_pop && item.last && out_valid_reg && !m_tready))
        else $error("result taken over a pending result");
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_pop && item.last) |=> (m_tvalid && !seen_first_reg))
        else $error("last item did not produce a result");
`endif

endmodule

[bench/tb_axis_extreme_vertex_finder_unit.sv]
`timescale 1ns / 1ps

module tb_axis_extreme_vertex_finder_unit;

    import evf_pkg::*;

    localparam int MAX_VERTS    = MAX_VERTICES_DEF;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS  = 10;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

    localparam logic [COORD_W-1:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] Q_MIN     = 32'h8000_0000;
    localparam logic [COORD_W-1:0] Q_ONE     = 32'h0001_0000;
    localparam logic [COORD_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;

    localparam logic signed [79:0] SAT_HI = 80'sd2147483647;
    localparam logic signed [79:0] SAT_LO = -80'sd2147483648;

    localparam logic [CFG_ADDR_W-1:0] ROW_REGS [NUM_REGS] = '{
        REG_ROW_X_AB, REG_ROW_X_CT, REG_ROW_Y_AB, REG_ROW_Y_CT, REG_ROW_Z_AB, REG_ROW_Z_CT
    };
    localparam logic [CFG_DATA_W-1:0] IDENTITY_ROWS [NUM_REGS] = '{
        RST_ROW_X_AB, RST_ROW_X_CT, RST_ROW_Y_AB, RST_ROW_Y_CT, RST_ROW_Z_AB, RST_ROW_Z_CT
    };

    // Direction order from bit 0 up: +X, -X, +Y, -Y, +Z, -Z.
    typedef struct packed {
        logic                                too_many;
        logic [NUM_DIRS-1:0][IDX_OUT_W-1:0] idx;
    } extremes_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               last;
        logic               known;
        extremes_t          want;
    } vertex_row_t;

    typedef enum int {
        XF_IDENTITY,
        XF_RANDOM,
        XF_ZERO,
        XF_ONES,
        XF_MAXPOS,
        XF_MAXNEG
    } xf_kind_e;

    // Typed results hold only under the identity transform; the hex index words run
    // from -Z down to +X.
    localparam vertex_row_t DIRECTED_ROWS [13] = '{
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
          '{1'b0, 96'h0000_0000_0000_0000_0000_0000}},
        '{Q_MAX, Q_MIN, 32'h0000_0000, 1'b0, 1'b0, '{1'b0, 96'h0}},
        '{Q_MIN, Q_MAX, 32'hFFFF_FFFF, 1'b0, 1'b0, '{1'b0, 96'h0}},
        '{32'h0000_0000, 32'h0000_0000, Q_MAX, 1'b1, 1'b1,
          '{1'b0, 96'h0001_0002_0000_0001_0001_0000}},
        '{32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 1'b0, 1'b0, '{1'b0, 96'h0}},
        '{32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 1'b0, 1'b0, '{1'b0, 96'h0}},
        '{32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 1'b1, 1'b1,
          '{1'b0, 96'h0000_0000_0000_0000_0000_0000}},
        '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 1'b0, 1'b0, '{1'b0, 96'h0}},
        '{32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 1'b0, 1'b0, '{1'b0, 96'h0}},
        '{32'h0000_0000, 32'hFFFF_FFFF, Q_MIN, 1'b1, 1'b0, '{1'b0, 96'h0}},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '{1'b0, 96'h0}},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '{1'b0, 96'h0}},
        '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1,
          '{1'b0, 96'h0000_0000_0002_0000_0000_0002}}
    };

    logic                                   aclk      = 1'b0;
    logic                                   aresetn   = 1'b0;
    logic                                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]                  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]                  cfg_wdata = '0;
    logic                                   s_tvalid  = 1'b0;
    logic                                   s_tready;
    // s_tdata: pos_x [31:0], pos_y [63:32], pos_z [95:64]
    logic [3*COORD_W-1:0]                   s_tdata   = '0;
    logic                                   s_tlast   = 1'b0;
    logic                                   m_tvalid;
    logic                                   m_tready  = 1'b0;
    // m_tdata: idx_pos_x, idx_neg_x, idx_pos_y, idx_neg_y, idx_pos_z, idx_neg_z
    logic [NUM_DIRS*IDX_OUT_W-1:0]          m_tdata;
    // m_tuser: too_many [0]
    logic                                   m_tuser;

    // Transform registers and per-mesh state of the predictor.
    logic [CFG_DATA_W-1:0]  row_regs [NUM_REGS];
    bit                     mesh_open;
    int unsigned            vtx_seen;
    bit                     overflowed;
    logic signed [31:0]     best_coord [NUM_DIRS];
    int unsigned            best_idx [NUM_DIRS];

    extremes_t pending_extremes [$];

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int holds_asked  = 0;
    int holds_served = 0;
    int hold_left    = 0;
    int mismatches   = 0;
    int cycles       = 0;

    axis_extreme_vertex_finder_unit #(
        .MAX_VERTICES (MAX_VERTS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles == LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // One row of the transform, floored to Q16.16 and clamped to 32 bits.
    function automatic logic signed [31:0] xform_coord(input logic [CFG_DATA_W-1:0] ab,
                                                       input logic [CFG_DATA_W-1:0] ct,
                                                       input logic signed [31:0] x,
                                                       input logic signed [31:0] y,
                                                       input logic signed [31:0] z);
        logic signed [31:0] ca, cb, cc, tr;
        longint             pa, pb, pc;
        logic signed [79:0] acc, shift_t, q;
        ca = ab[31:0];
        cb = ab[63:32];
        cc = ct[31:0];
        tr = ct[63:32];
        pa = longint'(ca) * longint'(x);
        pb = longint'(cb) * longint'(y);
        pc = longint'(cc) * longint'(z);
        shift_t = tr;
        acc = pa;
        acc = acc + pb + pc + (shift_t <<< 16);
        q = acc >>> 16;
        if (q > SAT_HI)
            q = SAT_HI;
        if (q < SAT_LO)
            q = SAT_LO;
        return q[31:0];
    endfunction

    function automatic void clear_mesh();
        mesh_open  = 1'b0;
        vtx_seen   = 0;
        overflowed = 1'b0;
        for (int k = 0; k < NUM_DIRS; k++) begin
            best_coord[k] = '0;
            best_idx[k]   = 0;
        end
    endfunction

    task automatic track_vertex(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                input logic [COORD_W-1:0] z, input logic last,
                                output logic produced, output extremes_t res);
        logic signed [31:0] c [NUM_AXES];
        logic signed [31:0] v;
        int unsigned        idx;
        logic               take;
        for (int a = 0; a < NUM_AXES; a++)
            c[a] = xform_coord(row_regs[2*a], row_regs[2*a+1], x, y, z);
        if (vtx_seen < MAX_VERTS) begin
            idx = vtx_seen;
            vtx_seen++;
        end else begin
            // Past the limit the index stays pinned at the top.
            idx = MAX_VERTS - 1;
            overflowed = 1'b1;
        end
        for (int k = 0; k < NUM_DIRS; k++) begin
            v = c[k/2];
            if (!mesh_open)
                take = 1'b1;
            else if (k % 2 == 0)
                take = v > best_coord[k];
            else
                take = v < best_coord[k];
            if (take) begin
                best_coord[k] = v;
                best_idx[k]   = idx;
            end
        end
        mesh_open = 1'b1;
        produced  = last;
        res       = '0;
        if (last) begin
            for (int k = 0; k < NUM_DIRS; k++)
                res.idx[k] = best_idx[k][IDX_OUT_W-1:0];
            res.too_many = overflowed;
            clear_mesh();
        end
    endtask

    // Entered and left at a falling edge; s_tvalid stays high for a following item.
    task automatic send_vertex(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic [COORD_W-1:0] z, input logic last,
                               input logic known, input extremes_t want);
        logic      produced;
        extremes_t res;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        s_tlast  <= last;
        do
            @(posedge aclk);
        while (!s_tready);
        track_vertex(x, y, z, last, produced, res);
        if (produced)
            pending_extremes.push_back(known ? want : res);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_extremes.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [COORD_W-1:0] pick_coef();
        case ($urandom_range(9))
            0: case ($urandom_range(5))
                   0: return Q_MAX;
                   1: return Q_MIN;
                   2: return '0;
                   3: return '1;
                   4: return Q_ONE;
                   default: return Q_NEG_ONE;
               endcase
            1, 2, 3, 4, 5: return 32'(int'($urandom_range(262144)) - 131072);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(9))
            0: case ($urandom_range(3))
                   0: return Q_MAX;
                   1: return Q_MIN;
                   2: return '0;
                   default: return '1;
               endcase
            // A handful of whole values makes ties common.
            1, 2, 3: return 32'((int'($urandom_range(6)) - 3) * 65536);
            4, 5, 6: return 32'(int'($urandom_range(2097152)) - 1048576);
            default: return $urandom();
        endcase
    endfunction

    task automatic load_transform(input xf_kind_e kind);
        logic [CFG_DATA_W-1:0] value;
        for (int r = 0; r < NUM_REGS; r++) begin
            case (kind)
                XF_IDENTITY: value = IDENTITY_ROWS[r];
                XF_RANDOM:   value = {pick_coef(), pick_coef()};
                XF_ZERO:     value = '0;
                XF_ONES:     value = '1;
                XF_MAXPOS:   value = {Q_MAX, Q_MAX};
                default:     value = {Q_MIN, Q_MIN};
            endcase
            cfg_wr_en   <= 1'b1;
            cfg_addr    <= ROW_REGS[r];
            cfg_wdata   <= value;
            row_regs[r]  = value;
            @(negedge aclk);
        end
        // Writes to the unused indexes must leave the transform alone.
        cfg_addr  <= REG_SPARE_A;
        cfg_wdata <= {$urandom(), $urandom()};
        @(negedge aclk);
        cfg_addr  <= REG_SPARE_B;
        cfg_wdata <= {$urandom(), $urandom()};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_meshes(input int count);
        int sent;
        int mesh_len;
        sent = 0;
        while (sent < count) begin
            mesh_len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            for (int i = 0; i < mesh_len; i++)
                send_vertex(pick_coord(), pick_coord(), pick_coord(), i == mesh_len - 1,
                            1'b0, '0);
            sent += mesh_len;
        end
    endtask

    always @(negedge aclk) begin
        if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        extremes_t got;
        extremes_t want;
        logic      bad;
        if (aresetn && m_tvalid && m_tready) begin
            got.idx      = m_tdata;
            got.too_many = m_tuser;
            if (pending_extremes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: idx %h too_many %b", got.idx, got.too_many);
            end else begin
                want = pending_extremes.pop_front();
                bad  = (got.too_many !== want.too_many);
                for (int k = 0; k < NUM_DIRS; k++)
                    if (got.idx[k] !== want.idx[k])
                        bad = 1'b1;
                if (bad) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected idx %h too_many %b, got idx %h too_many %b",
                                 want.idx, want.too_many, got.idx, got.too_many);
                end
            end
        end
    end

    initial begin
        for (int r = 0; r < NUM_REGS; r++)
            row_regs[r] = IDENTITY_ROWS[r];
        clear_mesh();
        tx_idle_pct = 29;
        rx_idle_pct = 49;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
            send_vertex(DIRECTED_ROWS[i].x, DIRECTED_ROWS[i].y, DIRECTED_ROWS[i].z,
                        DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);
        settle();

        // The same rows again with every coefficient and translation at the positive maximum.
        load_transform(XF_MAXPOS);
        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
            send_vertex(DIRECTED_ROWS[i].x, DIRECTED_ROWS[i].y, DIRECTED_ROWS[i].z,
                        DIRECTED_ROWS[i].last, 1'b0, '0);
        settle();

        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 29 : (mode == 1) ? 49 : 0;
            rx_idle_pct = (mode == 0) ? 49 : (mode == 1) ? 29 : 0;
            for (int pass_no = 0; pass_no < 3; pass_no++) begin
                load_transform(xf_kind_e'(XF_RANDOM + (mode * 3 + pass_no) % 5));
                if (mode == 0 && pass_no == 0) begin
                    // Single-vertex meshes against a stalled receiver back up the queue.
                    holds_asked++;
                    for (int i = 0; i < 30; i++)
                        send_vertex(pick_coord(), pick_coord(), pick_coord(), 1'b1, 1'b0, '0);
                end
                random_meshes(95);
                settle();
            end
        end

        if (mismatches == 0 && pending_extremes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
